// ----- src/lct_pkg.sv -----
// ----------------------------------------------------------------------------
// lct_pkg
// Shared constants, register codes and helpers for the LRU cache with expiry.
// ----------------------------------------------------------------------------
package lct_pkg;

   localparam int KEY_PORT_BITS   = 64;
   localparam int VALUE_PORT_BITS = 64;
   localparam int TIME_BITS       = 48;
   localparam int CNT_PORT_BITS   = 10;
   localparam int STAT_BITS       = 32;
   localparam int CSR_DATA_BITS   = 32;

   localparam logic [CNT_PORT_BITS-1:0] DEFAULT_LIMIT   = 10'd256;
   localparam logic [CNT_PORT_BITS-1:0] MAX_ENTRIES_RST = 10'd512;
   localparam logic [STAT_BITS-1:0]     TTL_RST         = 32'd300000;

   typedef enum logic {
      CSR_MAX_ENTRIES = 1'b0,
      CSR_TTL_MS      = 1'b1
   } csr_index_type;

   typedef enum logic {
      OP_LOOKUP = 1'b0,
      OP_INSERT = 1'b1
   } op_kind_type;

   function automatic logic [STAT_BITS-1:0] sat_inc(input logic [STAT_BITS-1:0] c);
      return (c == '1) ? c : c + STAT_BITS'(1);
   endfunction

endpackage

// ----- src/lct_queue.sv -----
// ----------------------------------------------------------------------------
// lct_queue
// Two-entry command queue between the classifier and the execution unit.
// ----------------------------------------------------------------------------
module lct_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       fill_ff, fill_in;
   logic             push, pop;

   assign push_ready = (fill_ff != 2'd2);
   assign pop_valid  = (fill_ff != 2'd0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- src/lct_front.sv -----
// ----------------------------------------------------------------------------
// lct_front
// Accepts requests, scans the tag memory for the key and the lowest free slot,
// and hands a classified command to the execution unit. Clears tags after reset.
// ----------------------------------------------------------------------------
module lct_front #(
   parameter int CAPACITY   = 512,
   parameter int KEY_BITS   = 64,
   parameter int VALUE_BITS = 64,
   parameter int SW         = $clog2(CAPACITY),
   parameter int CMD_BITS   = 3 + KEY_BITS + VALUE_BITS + lct_pkg::TIME_BITS + 2 * SW
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_kind,
   input  logic [lct_pkg::KEY_PORT_BITS-1:0]   req_key,
   input  logic [lct_pkg::VALUE_PORT_BITS-1:0] req_value,
   input  logic [lct_pkg::TIME_BITS-1:0]       req_now_ms,
   output logic                                cmd_valid,
   input  logic                                cmd_ready,
   output logic [CMD_BITS-1:0]                 cmd_data,
   input  logic                                tag_we,
   input  logic [SW-1:0]                       tag_idx,
   input  logic                                tag_valid,
   input  logic [KEY_BITS-1:0]                 tag_key,
   input  logic                                back_done
);
   import lct_pkg::*;

   typedef enum logic [5:0] {
      F_CLEAR = 6'b000001,
      F_IDLE  = 6'b000010,
      F_SCAN  = 6'b000100,
      F_LAST  = 6'b001000,
      F_PUSH  = 6'b010000,
      F_WAIT  = 6'b100000
   } front_state_type;

   front_state_type          state_ff, state_in;
   logic [SW-1:0]            ptr_ff, ptr_in;
   logic                     chk_ff, chk_in;
   logic [SW-1:0]            idx_ff;
   logic                     hit_ff, hit_in;
   logic [SW-1:0]            hit_slot_ff, hit_slot_in;
   logic                     free_ok_ff, free_ok_in;
   logic [SW-1:0]            free_slot_ff, free_slot_in;
   logic                     kind_ff;
   logic [KEY_BITS-1:0]      key_ff;
   logic [VALUE_BITS-1:0]    value_ff;
   logic [TIME_BITS-1:0]     now_ff;
   logic [KEY_BITS:0]        tag_mem [CAPACITY];
   logic [KEY_BITS:0]        tag_rd_ff;
   logic                     ptr_last;
   logic                     mem_we;
   logic [SW-1:0]            mem_wa;
   logic [KEY_BITS:0]        mem_wd;
   logic                     accept;

   assign ptr_last  = (ptr_ff == SW'(CAPACITY - 1));
   assign req_ready = (state_ff == F_IDLE);
   assign accept    = req_valid && req_ready;
   assign cmd_valid = (state_ff == F_PUSH);
   assign cmd_data  = {kind_ff, key_ff, value_ff, now_ff, hit_ff, hit_slot_ff,
                       free_ok_ff, free_slot_ff};

   assign mem_we = (state_ff == F_CLEAR) || tag_we;
   assign mem_wa = (state_ff == F_CLEAR) ? ptr_ff : tag_idx;
   assign mem_wd = (state_ff == F_CLEAR) ? '0 : {tag_valid, tag_key};

   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      chk_in       = 1'b0;
      hit_in       = hit_ff;
      hit_slot_in  = hit_slot_ff;
      free_ok_in   = free_ok_ff;
      free_slot_in = free_slot_ff;

      if (chk_ff) begin
         if (tag_rd_ff[KEY_BITS] && (tag_rd_ff[KEY_BITS-1:0] == key_ff)) begin
            hit_in      = 1'b1;
            hit_slot_in = idx_ff;
         end
         if (!tag_rd_ff[KEY_BITS] && !free_ok_ff) begin
            free_ok_in   = 1'b1;
            free_slot_in = idx_ff;
         end
      end

      unique case (state_ff)
         F_CLEAR: begin
            ptr_in = ptr_last ? '0 : ptr_ff + SW'(1);
            if (ptr_last) begin
               state_in = F_IDLE;
            end
         end
         F_IDLE: begin
            if (req_valid) begin
               state_in   = F_SCAN;
               ptr_in     = '0;
               hit_in     = 1'b0;
               free_ok_in = 1'b0;
            end
         end
         F_SCAN: begin
            chk_in = 1'b1;
            ptr_in = ptr_last ? '0 : ptr_ff + SW'(1);
            if (ptr_last) begin
               state_in = F_LAST;
            end
         end
         F_LAST: begin
            state_in = F_PUSH;
         end
         F_PUSH: begin
            if (cmd_ready) begin
               state_in = F_WAIT;
            end
         end
         F_WAIT: begin
            if (back_done) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= F_CLEAR;
         ptr_ff     <= '0;
         chk_ff     <= 1'b0;
         hit_ff     <= 1'b0;
         free_ok_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         ptr_ff     <= ptr_in;
         chk_ff     <= chk_in;
         hit_ff     <= hit_in;
         free_ok_ff <= free_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= ptr_ff;
      hit_slot_ff  <= hit_slot_in;
      free_slot_ff <= free_slot_in;
      if (accept) begin
         kind_ff  <= req_kind;
         key_ff   <= req_key[KEY_BITS-1:0];
         value_ff <= req_value[VALUE_BITS-1:0];
         now_ff   <= req_now_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         tag_mem[mem_wa] <= mem_wd;
      end
      tag_rd_ff <= tag_mem[ptr_ff];
   end

endmodule

// ----- src/lct_back.sv -----
// ----------------------------------------------------------------------------
// lct_back
// Executes classified commands: recency list upkeep, expiry, eviction,
// placement, counters, configuration and the result register.
// ----------------------------------------------------------------------------
module lct_back #(
   parameter int CAPACITY   = 512,
   parameter int KEY_BITS   = 64,
   parameter int VALUE_BITS = 64,
   parameter int SW         = $clog2(CAPACITY),
   parameter int CW         = $clog2(CAPACITY + 1),
   parameter int CMD_BITS   = 3 + KEY_BITS + VALUE_BITS + lct_pkg::TIME_BITS + 2 * SW
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  lct_pkg::csr_index_type              csr_index,
   input  logic [lct_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   input  logic                                cmd_valid,
   output logic                                cmd_ready,
   input  logic [CMD_BITS-1:0]                 cmd_data,
   output logic                                tag_we,
   output logic [SW-1:0]                       tag_idx,
   output logic                                tag_valid,
   output logic [KEY_BITS-1:0]                 tag_key,
   output logic                                back_done,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_found,
   output logic [lct_pkg::VALUE_PORT_BITS-1:0] rsp_read_value,
   output logic                                rsp_expired,
   output logic [lct_pkg::CNT_PORT_BITS-1:0]   rsp_evicted_now,
   output logic [lct_pkg::CNT_PORT_BITS-1:0]   rsp_occupancy,
   output logic [lct_pkg::STAT_BITS-1:0]       rsp_hit_total,
   output logic [lct_pkg::STAT_BITS-1:0]       rsp_miss_total,
   output logic [lct_pkg::STAT_BITS-1:0]       rsp_evict_total
);
   import lct_pkg::*;

   localparam int LIMW = (CW > CNT_PORT_BITS) ? CW : CNT_PORT_BITS;

   typedef enum logic [7:0] {
      B_IDLE   = 8'b00000001,
      B_READ   = 8'b00000010,
      B_DECIDE = 8'b00000100,
      B_LINK   = 8'b00001000,
      B_EVCHK  = 8'b00010000,
      B_EVDROP = 8'b00100000,
      B_PLACE  = 8'b01000000,
      B_RESP   = 8'b10000000
   } back_state_type;

   back_state_type              state_ff, state_in;
   logic [CMD_BITS-1:0]         cmd_ff;
   logic                        c_kind;
   logic [KEY_BITS-1:0]         c_key;
   logic [VALUE_BITS-1:0]       c_value;
   logic [TIME_BITS-1:0]        c_now;
   logic                        c_hit;
   logic [SW-1:0]               c_hit_slot;
   logic                        c_free_ok;
   logic [SW-1:0]               c_free_slot;

   logic [CNT_PORT_BITS-1:0]    max_ff, max_in;
   logic [STAT_BITS-1:0]        ttl_ff, ttl_in;
   logic [SW-1:0]               newest_ff, newest_in;
   logic [SW-1:0]               oldest_ff, oldest_in;
   logic [CW-1:0]               count_ff, count_in;
   logic [STAT_BITS-1:0]        hit_cnt_ff, hit_cnt_in;
   logic [STAT_BITS-1:0]        miss_cnt_ff, miss_cnt_in;
   logic [STAT_BITS-1:0]        evc_cnt_ff, evc_cnt_in;
   logic [CW-1:0]               evicted_ff, evicted_in;
   logic                        free_ok_ff, free_ok_in;
   logic [SW-1:0]               free_slot_ff, free_slot_in;
   logic                        found_ff, found_in;
   logic [VALUE_PORT_BITS-1:0]  value_ff, value_in;
   logic                        expired_ff, expired_in;

   logic [VALUE_BITS-1:0]       data_mem  [CAPACITY];
   logic [TIME_BITS-1:0]        exp_mem   [CAPACITY];
   logic [SW-1:0]               newer_mem [CAPACITY];
   logic [SW-1:0]               older_mem [CAPACITY];
   logic [VALUE_BITS-1:0]       data_rd_ff;
   logic [TIME_BITS-1:0]        exp_rd_ff;
   logic [SW-1:0]               newer_rd_ff;
   logic [SW-1:0]               older_rd_ff;

   logic [SW-1:0]               rd_slot;
   logic                        data_we, exp_we, nw_we, ol_we;
   logic [SW-1:0]               data_wa, nw_wa, nw_wd, ol_wa, ol_wd;
   logic [TIME_BITS:0]          exp_sum;
   logic [TIME_BITS-1:0]        exp_new;
   logic [LIMW-1:0]             lim_raw, lim;
   logic                        do_drop, do_unlink;
   logic [SW-1:0]               u_slot;
   logic                        pop;

   assign {c_kind, c_key, c_value, c_now, c_hit, c_hit_slot, c_free_ok, c_free_slot} = cmd_ff;

   assign pop       = cmd_valid && cmd_ready;
   assign rd_slot   = (state_ff == B_READ) ? c_hit_slot : oldest_ff;
   assign u_slot    = (state_ff == B_DECIDE) ? c_hit_slot : oldest_ff;
   assign exp_sum   = {1'b0, c_now} + (TIME_BITS + 1)'(ttl_ff);
   assign exp_new   = (ttl_ff == '0) ? '0 : (exp_sum[TIME_BITS] ? '1 : exp_sum[TIME_BITS-1:0]);
   assign lim_raw   = (max_ff == '0) ? LIMW'(DEFAULT_LIMIT) : LIMW'(max_ff);
   assign lim       = (lim_raw > LIMW'(CAPACITY)) ? LIMW'(CAPACITY) : lim_raw;

   assign rsp_valid       = (state_ff == B_RESP);
   assign rsp_found       = found_ff;
   assign rsp_read_value  = value_ff;
   assign rsp_expired     = expired_ff;
   assign rsp_evicted_now = CNT_PORT_BITS'(evicted_ff);
   assign rsp_occupancy   = CNT_PORT_BITS'(count_ff);
   assign rsp_hit_total   = hit_cnt_ff;
   assign rsp_miss_total  = miss_cnt_ff;
   assign rsp_evict_total = evc_cnt_ff;
   assign tag_key         = c_key;

   always_comb begin
      max_in = max_ff;
      ttl_in = ttl_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_MAX_ENTRIES: max_in = csr_wdata[CNT_PORT_BITS-1:0];
            CSR_TTL_MS:      ttl_in = csr_wdata;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      newest_in    = newest_ff;
      oldest_in    = oldest_ff;
      count_in     = count_ff;
      hit_cnt_in   = hit_cnt_ff;
      miss_cnt_in  = miss_cnt_ff;
      evc_cnt_in   = evc_cnt_ff;
      evicted_in   = evicted_ff;
      free_ok_in   = free_ok_ff;
      free_slot_in = free_slot_ff;
      found_in     = found_ff;
      value_in     = value_ff;
      expired_in   = expired_ff;
      cmd_ready    = 1'b0;
      back_done    = 1'b0;
      do_drop      = 1'b0;
      do_unlink    = 1'b0;
      data_we      = 1'b0;
      exp_we       = 1'b0;
      data_wa      = c_hit_slot;
      nw_we        = 1'b0;
      nw_wa        = newest_ff;
      nw_wd        = c_hit_slot;
      ol_we        = 1'b0;
      ol_wa        = c_hit_slot;
      ol_wd        = newest_ff;
      tag_we       = 1'b0;
      tag_idx      = u_slot;
      tag_valid    = 1'b0;

      unique case (state_ff)
         B_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               state_in   = B_READ;
               evicted_in = '0;
               found_in   = 1'b0;
               value_in   = '0;
               expired_in = 1'b0;
            end
         end
         B_READ: begin
            free_ok_in   = c_free_ok;
            free_slot_in = c_free_slot;
            if (c_hit) begin
               state_in = B_DECIDE;
            end else if (c_kind == OP_LOOKUP) begin
               miss_cnt_in = sat_inc(miss_cnt_ff);
               state_in    = B_RESP;
               back_done   = 1'b1;
            end else begin
               state_in = B_EVCHK;
            end
         end
         B_DECIDE: begin
            if (c_kind == OP_LOOKUP) begin
               if ((exp_rd_ff != '0) && (c_now > exp_rd_ff)) begin
                  do_drop     = 1'b1;
                  miss_cnt_in = sat_inc(miss_cnt_ff);
                  expired_in  = 1'b1;
                  state_in    = B_RESP;
                  back_done   = 1'b1;
               end else begin
                  hit_cnt_in = sat_inc(hit_cnt_ff);
                  found_in   = 1'b1;
                  value_in   = VALUE_PORT_BITS'(data_rd_ff);
               end
            end else begin
               data_we  = 1'b1;
               exp_we   = 1'b1;
               found_in = 1'b1;
            end
            if (!do_drop) begin
               if (c_hit_slot == newest_ff) begin
                  state_in  = B_RESP;
                  back_done = 1'b1;
               end else begin
                  do_unlink = 1'b1;
                  state_in  = B_LINK;
               end
            end
         end
         B_LINK: begin
            nw_we     = 1'b1;
            ol_we     = 1'b1;
            newest_in = c_hit_slot;
            state_in  = B_RESP;
            back_done = 1'b1;
         end
         B_EVCHK: begin
            if ((LIMW'(count_ff) >= lim) && (count_ff != '0)) begin
               state_in = B_EVDROP;
            end else begin
               state_in = B_PLACE;
            end
         end
         B_EVDROP: begin
            do_drop    = 1'b1;
            evc_cnt_in = sat_inc(evc_cnt_ff);
            evicted_in = evicted_ff + CW'(1);
            if (!free_ok_ff || (oldest_ff < free_slot_ff)) begin
               free_ok_in   = 1'b1;
               free_slot_in = oldest_ff;
            end
            state_in = B_EVCHK;
         end
         B_PLACE: begin
            if (free_ok_ff) begin
               tag_we    = 1'b1;
               tag_idx   = free_slot_ff;
               tag_valid = 1'b1;
               data_we   = 1'b1;
               exp_we    = 1'b1;
               data_wa   = free_slot_ff;
               newest_in = free_slot_ff;
               if (count_ff == '0) begin
                  oldest_in = free_slot_ff;
               end else begin
                  nw_we = 1'b1;
                  nw_wd = free_slot_ff;
                  ol_we = 1'b1;
                  ol_wa = free_slot_ff;
               end
               count_in = count_ff + CW'(1);
            end
            state_in  = B_RESP;
            back_done = 1'b1;
         end
         B_RESP: begin
            if (rsp_ready) begin
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase

      if (do_drop && (count_ff <= CW'(1))) begin
         newest_in = '0;
         oldest_in = '0;
      end else if (do_drop || do_unlink) begin
         newest_in = (u_slot == newest_ff) ? older_rd_ff : newest_ff;
         oldest_in = (u_slot == oldest_ff) ? newer_rd_ff : oldest_ff;
         if (u_slot != newest_ff) begin
            ol_we = 1'b1;
            ol_wa = newer_rd_ff;
            ol_wd = older_rd_ff;
         end
         if (u_slot != oldest_ff) begin
            nw_we = 1'b1;
            nw_wa = older_rd_ff;
            nw_wd = newer_rd_ff;
         end
      end
      if (do_drop) begin
         tag_we  = 1'b1;
         tag_idx = u_slot;
         if (count_ff != '0) begin
            count_in = count_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= B_IDLE;
         max_ff      <= MAX_ENTRIES_RST;
         ttl_ff      <= TTL_RST;
         newest_ff   <= '0;
         oldest_ff   <= '0;
         count_ff    <= '0;
         hit_cnt_ff  <= '0;
         miss_cnt_ff <= '0;
         evc_cnt_ff  <= '0;
         free_ok_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         max_ff      <= max_in;
         ttl_ff      <= ttl_in;
         newest_ff   <= newest_in;
         oldest_ff   <= oldest_in;
         count_ff    <= count_in;
         hit_cnt_ff  <= hit_cnt_in;
         miss_cnt_ff <= miss_cnt_in;
         evc_cnt_ff  <= evc_cnt_in;
         free_ok_ff  <= free_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cmd_ff <= cmd_data;
      end
      evicted_ff   <= evicted_in;
      free_slot_ff <= free_slot_in;
      found_ff     <= found_in;
      value_ff     <= value_in;
      expired_ff   <= expired_in;
   end

   always_ff @(posedge clock) begin
      if (data_we) begin
         data_mem[data_wa] <= c_value;
      end
      if (exp_we) begin
         exp_mem[data_wa] <= exp_new;
      end
      if (nw_we) begin
         newer_mem[nw_wa] <= nw_wd;
      end
      if (ol_we) begin
         older_mem[ol_wa] <= ol_wd;
      end
      data_rd_ff  <= data_mem[rd_slot];
      exp_rd_ff   <= exp_mem[rd_slot];
      newer_rd_ff <= newer_mem[rd_slot];
      older_rd_ff <= older_mem[rd_slot];
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_expired_not_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_RESP) && expired_ff |-> !found_ff)
      else $error("expired result also marked found");

   a_place_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_PLACE) && free_ok_ff |=> count_ff == $past(count_ff) + CW'(1))
      else $error("placement did not grow the entry count");

endmodule

// ----- src/lru_cache_with_ttl.sv -----
// The tag memory is scanned one entry a cycle for the key and the lowest free
// slot; then the back end updates the recency list or places the item, with a
// check and a drop step for every eviction.
// One item is in work at a time; the next is accepted while the previous result
// waits in its register. After reset a clearing pass runs over every tag entry,
// during which no item is accepted; configuration writes are taken.
// ----------------------------------------------------------------------------
// lru_cache_with_ttl
// Keyed store with least-recently-used replacement and per-entry expiry.
// ----------------------------------------------------------------------------
module lru_cache_with_ttl #(
   parameter int CAPACITY   = 512,
   parameter int KEY_BITS   = 64,
   parameter int VALUE_BITS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  lct_pkg::csr_index_type              csr_index,
   input  logic [lct_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_kind,
   input  logic [lct_pkg::KEY_PORT_BITS-1:0]   req_key,
   input  logic [lct_pkg::VALUE_PORT_BITS-1:0] req_value,
   input  logic [lct_pkg::TIME_BITS-1:0]       req_now_ms,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_found,
   output logic [lct_pkg::VALUE_PORT_BITS-1:0] rsp_read_value,
   output logic                                rsp_expired,
   output logic [lct_pkg::CNT_PORT_BITS-1:0]   rsp_evicted_now,
   output logic [lct_pkg::CNT_PORT_BITS-1:0]   rsp_occupancy,
   output logic [lct_pkg::STAT_BITS-1:0]       rsp_hit_total,
   output logic [lct_pkg::STAT_BITS-1:0]       rsp_miss_total,
   output logic [lct_pkg::STAT_BITS-1:0]       rsp_evict_total
);
   import lct_pkg::*;

   localparam int SW       = $clog2(CAPACITY);
   localparam int CMD_BITS = 3 + KEY_BITS + VALUE_BITS + TIME_BITS + 2 * SW;

   logic                 fq_valid, fq_ready;
   logic [CMD_BITS-1:0]  fq_data;
   logic                 qb_valid, qb_ready;
   logic [CMD_BITS-1:0]  qb_data;
   logic                 tag_we;
   logic [SW-1:0]        tag_idx;
   logic                 tag_valid;
   logic [KEY_BITS-1:0]  tag_key;
   logic                 back_done;

   lct_front #(
      .CAPACITY   (CAPACITY),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_kind   (req_kind),
      .req_key    (req_key),
      .req_value  (req_value),
      .req_now_ms (req_now_ms),
      .cmd_valid  (fq_valid),
      .cmd_ready  (fq_ready),
      .cmd_data   (fq_data),
      .tag_we     (tag_we),
      .tag_idx    (tag_idx),
      .tag_valid  (tag_valid),
      .tag_key    (tag_key),
      .back_done  (back_done)
   );

   lct_queue #(
      .WIDTH (CMD_BITS)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_data  (fq_data),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_data   (qb_data)
   );

   lct_back #(
      .CAPACITY   (CAPACITY),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .cmd_valid       (qb_valid),
      .cmd_ready       (qb_ready),
      .cmd_data        (qb_data),
      .tag_we          (tag_we),
      .tag_idx         (tag_idx),
      .tag_valid       (tag_valid),
      .tag_key         (tag_key),
      .back_done       (back_done),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_found       (rsp_found),
      .rsp_read_value  (rsp_read_value),
      .rsp_expired     (rsp_expired),
      .rsp_evicted_now (rsp_evicted_now),
      .rsp_occupancy   (rsp_occupancy),
      .rsp_hit_total   (rsp_hit_total),
      .rsp_miss_total  (rsp_miss_total),
      .rsp_evict_total (rsp_evict_total)
   );

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the LRU cache with expiry. A behavioural model of
// the store runs alongside the design, and each response transfer is compared
// field by field in order. Directed cases cover the edges; random phases
// cover several limit and lifetime settings under random flow control.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lct_pkg::*;

   localparam int SLOTS = 512;
   localparam logic [47:0] TIME_TOP = 48'hFFFF_FFFF_FFFF;

   typedef struct packed {
      logic        found;
      logic [63:0] read_value;
      logic        expired;
      logic [9:0]  evicted_now;
      logic [9:0]  occupancy;
      logic [31:0] hit_total;
      logic [31:0] miss_total;
      logic [31:0] evict_total;
   } cache_rsp_t;

   logic clock = 1'b0;
   logic reset;
   logic csr_write;
   csr_index_type csr_index;
   logic [31:0] csr_wdata;
   logic req_valid, req_ready, req_kind;
   logic [63:0] req_key, req_value;
   logic [47:0] req_now_ms;
   logic rsp_valid, rsp_ready, rsp_found, rsp_expired;
   logic [63:0] rsp_read_value;
   logic [9:0] rsp_evicted_now, rsp_occupancy;
   logic [31:0] rsp_hit_total, rsp_miss_total, rsp_evict_total;

   lru_cache_with_ttl u_dut (.*);

   // model state
   logic [9:0]  lim_reg;
   logic [31:0] ttl_reg;
   bit          s_valid [SLOTS];
   logic [63:0] s_key [SLOTS];
   logic [63:0] s_data [SLOTS];
   logic [47:0] s_exp [SLOTS];
   int          s_newer [SLOTS];
   int          s_older [SLOTS];
   int          newest, oldest, held;
   logic [31:0] hits, misses, evicts;

   cache_rsp_t  pending_rsp [$];
   int          errors = 0;
   int          burst_left = 0;
   int          hold_cycles = 0;
   int          stall_mode = 0;
   logic [47:0] clk_ms = 0;
   logic [63:0] key_pool [16];

   initial forever #6 clock = ~clock;

   function automatic logic [31:0] bump(input logic [31:0] c);
      return (c == '1) ? c : c + 32'd1;
   endfunction

   function automatic logic [47:0] expiry_at(input logic [47:0] now);
      logic [48:0] sum;
      if (ttl_reg == 0) return '0;
      sum = {1'b0, now} + {17'd0, ttl_reg};
      return sum[48] ? TIME_TOP : sum[47:0];
   endfunction

   task automatic unlink(input int s);
      if (s == newest) newest = s_older[s];
      else s_older[s_newer[s]] = s_older[s];
      if (s == oldest) oldest = s_newer[s];
      else s_newer[s_older[s]] = s_newer[s];
   endtask

   task automatic link_top(input int s, input bit empty);
      if (empty) begin
         newest = s;
         oldest = s;
      end else begin
         s_newer[newest] = s;
         s_older[s] = newest;
         newest = s;
      end
   endtask

   task automatic make_newest(input int s);
      if (s != newest) begin
         unlink(s);
         link_top(s, 1'b0);
      end
   endtask

   task automatic drop(input int s);
      if (held <= 1) begin
         newest = 0;
         oldest = 0;
      end else begin
         unlink(s);
      end
      s_valid[s] = 0;
      if (held > 0) held--;
   endtask

   task automatic predict_cache(input logic kind, input logic [63:0] key,
                                input logic [63:0] val, input logic [47:0] now);
      cache_rsp_t r;
      int hit, lim, s, nev;
      r = '0;
      hit = -1;
      nev = 0;
      for (int i = 0; i < SLOTS; i++)
         if (hit < 0 && s_valid[i] && s_key[i] == key) hit = i;
      if (kind == OP_LOOKUP) begin
         if (hit < 0) begin
            misses = bump(misses);
         end else if (s_exp[hit] != 0 && now > s_exp[hit]) begin
            drop(hit);
            misses = bump(misses);
            r.expired = 1'b1;
         end else begin
            make_newest(hit);
            hits = bump(hits);
            r.found = 1'b1;
            r.read_value = s_data[hit];
         end
      end else if (hit >= 0) begin
         s_data[hit] = val;
         s_exp[hit] = expiry_at(now);
         make_newest(hit);
         r.found = 1'b1;
      end else begin
         lim = (lim_reg == 0) ? 256 : ((lim_reg > SLOTS) ? SLOTS : int'(lim_reg));
         while (held >= lim && held > 0) begin
            drop(oldest);
            evicts = bump(evicts);
            nev++;
         end
         s = 0;
         while (s < SLOTS && s_valid[s]) s++;
         if (s < SLOTS) begin
            s_valid[s] = 1;
            s_key[s] = key;
            s_data[s] = val;
            s_exp[s] = expiry_at(now);
            link_top(s, held == 0);
            held++;
         end
      end
      r.evicted_now = nev[9:0];
      r.occupancy = held[9:0];
      r.hit_total = hits;
      r.miss_total = misses;
      r.evict_total = evicts;
      pending_rsp.push_back(r);
   endtask

   // sender: one transfer, then a random gap at the end of a burst
   task automatic send_req(input logic kind, input logic [63:0] key,
                           input logic [63:0] val, input logic [47:0] now);
      int gap;
      req_valid <= 1'b1;
      req_kind <= kind;
      req_key <= key;
      req_value <= val;
      req_now_ms <= now;
      do @(posedge clock); while (!req_ready);
      predict_cache(kind, key, val, now);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 8);
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_set(input csr_index_type idx, input logic [31:0] data);
      drain();
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_MAX_ENTRIES) lim_reg = data[9:0];
      else ttl_reg = data;
   endtask

   // receiver: checks transfers and drives its own stall pattern
   always @(posedge clock) begin
      cache_rsp_t e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $error("response with nothing expected");
            errors++;
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_found !== e.found) begin
               $error("found exp %0h got %0h", e.found, rsp_found); errors++;
            end
            if (rsp_read_value !== e.read_value) begin
               $error("read_value exp %0h got %0h", e.read_value, rsp_read_value);
               errors++;
            end
            if (rsp_expired !== e.expired) begin
               $error("expired exp %0h got %0h", e.expired, rsp_expired); errors++;
            end
            if (rsp_evicted_now !== e.evicted_now) begin
               $error("evicted_now exp %0d got %0d", e.evicted_now, rsp_evicted_now);
               errors++;
            end
            if (rsp_occupancy !== e.occupancy) begin
               $error("occupancy exp %0d got %0d", e.occupancy, rsp_occupancy);
               errors++;
            end
            if (rsp_hit_total !== e.hit_total) begin
               $error("hit_total exp %0d got %0d", e.hit_total, rsp_hit_total);
               errors++;
            end
            if (rsp_miss_total !== e.miss_total) begin
               $error("miss_total exp %0d got %0d", e.miss_total, rsp_miss_total);
               errors++;
            end
            if (rsp_evict_total !== e.evict_total) begin
               $error("evict_total exp %0d got %0d", e.evict_total, rsp_evict_total);
               errors++;
            end
         end
      end
      if ($urandom_range(0, 127) == 0) stall_mode = $urandom_range(0, 2);
      if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_ready <= 1'b0;
      end else begin
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            default: rsp_ready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   task automatic test_directed;
      // empty store, extremes of key, value and time
      send_req(OP_LOOKUP, 64'd0, 64'd0, 48'd0);
      send_req(OP_INSERT, 64'd0, 64'd0, 48'd0);
      send_req(OP_INSERT, '1, '1, TIME_TOP);
      send_req(OP_LOOKUP, '1, 64'd0, TIME_TOP);
      send_req(OP_LOOKUP, 64'd0, '1, 48'd300000);
      send_req(OP_INSERT, 64'd0, 64'h5555_AAAA_5555_AAAA, 48'd5);
      send_req(OP_LOOKUP, 64'd0, 64'd0, 48'd300001);
      // expiry boundary: equal is live, one past is gone
      csr_set(CSR_TTL_MS, 32'd10);
      send_req(OP_INSERT, 64'h77, 64'h1234, 48'd100);
      send_req(OP_LOOKUP, 64'h77, 64'd0, 48'd110);
      send_req(OP_LOOKUP, 64'h77, 64'd0, 48'd111);
      send_req(OP_LOOKUP, 64'h77, 64'd0, 48'd111);
      // zero lifetime never expires; saturated expiry
      csr_set(CSR_TTL_MS, 32'd0);
      send_req(OP_INSERT, 64'h88, 64'h99, 48'd1);
      send_req(OP_LOOKUP, 64'h88, 64'd0, TIME_TOP);
      csr_set(CSR_TTL_MS, 32'hFFFF_FFFF);
      send_req(OP_INSERT, 64'h99, 64'h42, TIME_TOP - 48'd5);
      send_req(OP_LOOKUP, 64'h99, 64'd0, TIME_TOP);
      // lowered limit evicts several at once, then a tiny limit
      csr_set(CSR_MAX_ENTRIES, 32'hFFFF_FC02);
      send_req(OP_INSERT, 64'hA0, 64'h1, 48'd7);
      send_req(OP_INSERT, 64'hA1, 64'h2, 48'd8);
      send_req(OP_LOOKUP, 64'hA0, 64'd0, 48'd9);
      send_req(OP_INSERT, 64'hA2, 64'h3, 48'd9);
      csr_set(CSR_MAX_ENTRIES, 32'd1);
      send_req(OP_INSERT, 64'hA3, 64'h4, 48'd10);
      send_req(OP_LOOKUP, 64'hA0, 64'd0, 48'd11);
   endtask

   task automatic test_random_phase(input logic [31:0] lim, input logic [31:0] ttl,
                                    input int count);
      logic kind;
      logic [63:0] key;
      csr_set(CSR_MAX_ENTRIES, lim);
      csr_set(CSR_TTL_MS, ttl);
      for (int i = 0; i < 16; i++) key_pool[i] = {$urandom, $urandom};
      for (int n = 0; n < count; n++) begin
         kind = 1'($urandom_range(0, 1));
         key = ($urandom_range(0, 15) == 0) ? {$urandom, $urandom}
                                            : key_pool[$urandom_range(0, 15)];
         if ($urandom_range(0, 40) == 0) clk_ms = 48'({$urandom, $urandom} >> 16);
         else clk_ms = clk_ms + $urandom_range(0, 30);
         send_req(kind, key, {$urandom, $urandom}, clk_ms);
      end
   endtask

   task automatic test_backpressure;
      hold_cycles = 5000;
      for (int n = 0; n < 12; n++) begin
         clk_ms = clk_ms + 1;
         send_req(1'($urandom_range(0, 1)), key_pool[$urandom_range(0, 15)],
                  {$urandom, $urandom}, clk_ms);
      end
   endtask

   initial begin
      reset <= 1'b1;
      csr_write <= 1'b0;
      csr_index <= CSR_MAX_ENTRIES;
      csr_wdata <= '0;
      req_valid <= 1'b0;
      req_kind <= 1'b0;
      req_key <= '0;
      req_value <= '0;
      req_now_ms <= '0;
      rsp_ready <= 1'b0;
      lim_reg = MAX_ENTRIES_RST;
      ttl_reg = TTL_RST;
      for (int i = 0; i < SLOTS; i++) s_valid[i] = 0;
      newest = 0; oldest = 0; held = 0;
      hits = 0; misses = 0; evicts = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_phase(32'd8, 32'd50, 110);
      test_random_phase(32'd1, 32'd5, 100);
      test_random_phase(32'd0, $urandom, 110);
      test_random_phase(32'd700, 32'hFFFF_FFFF, 110);
      test_random_phase(32'd12, 32'd0, 110);
      test_random_phase(32'd3, 32'd20, 110);
      test_backpressure();
      drain();
      repeat (600) @(posedge clock);
      if (errors == 0) $display("tb: done, clean");
      else $display("tb: done, errors");
      $finish;
   end

   initial begin
      #60ms;
      $display("tb: done, errors");
      $finish;
   end
endmodule

// ----- filelist.f -----
src/lct_pkg.sv
src/lct_queue.sv
src/lct_front.sv
src/lct_back.sv
src/lru_cache_with_ttl.sv
bench/tb.sv
